// ===== sv/rc_pkg.sv =====
// Shared types and constants for the Rice codec.
`default_nettype none
package rc_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned LEN_W   = 7;
    localparam int unsigned K_W     = 5;
    localparam int unsigned ACC_W   = 16;
    localparam logic [K_W-1:0] K_MAX     = 5'd16;
    localparam logic [K_W-1:0] K_RESET   = 5'd6;

    typedef enum logic [0:0] {
        CFG_MODE   = 1'b0,
        CFG_SUFFIX = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    typedef enum logic [0:0] {
        KIND_ENCODE = 1'b0,
        KIND_DECODE = 1'b1
    } kind_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value_in;
        logic               code_bit;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0]  code_word;
        logic [LEN_W-1:0]   code_length;
        logic               too_long;
        logic [VALUE_W-1:0] decoded_value;
        logic               value_overflow;
        logic               result_kind;
    } out_item_t;

endpackage
`default_nettype wire

// ===== sv/rc_enc.sv =====
// Rice encoder: one value into one packed code word, combinational.
`default_nettype none
module rc_enc
    import rc_pkg::*;
#(
    parameter int unsigned MAX_CODE_BITS = 64
) (
    input  wire logic [VALUE_W-1:0] value_in,
    input  wire logic [K_W-1:0]     k,
    output out_item_t               result
);
    localparam int unsigned SUM_W = VALUE_W + 2;

    logic [VALUE_W-1:0] quot;
    logic [SUM_W-1:0]   len;
    logic               over;
    logic [ACC_W-1:0]   rem;
    logic [5:0]         q6;
    logic [WORD_W-1:0]  ones;
    logic [WORD_W-1:0]  tail;

    always_comb begin
        quot = value_in >> k;
        len  = SUM_W'(quot) + SUM_W'(k) + SUM_W'(1);
        over = len > SUM_W'(MAX_CODE_BITS);
        rem  = value_in[ACC_W-1:0] & ~({ACC_W{1'b1}} << k);
        q6   = quot[5:0];
        ones = (WORD_W'(1) << q6) - WORD_W'(1);
        // shift of 64 (only when k is 0) drops the empty suffix
        tail = WORD_W'(rem) << ({1'b0, q6} + 7'd1);

        result                = '0;
        result.result_kind    = KIND_ENCODE;
        result.too_long       = over;
        if (!over) begin
            result.code_word   = ones | tail;
            result.code_length = len[LEN_W-1:0];
        end
    end
endmodule
`default_nettype wire

// ===== sv/rc_dec.sv =====
// Rice decoder: running bit-by-bit state and value assembly.
`default_nettype none
module rc_dec
    import rc_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 32
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           step,
    input  wire logic           code_bit,
    input  wire logic [K_W-1:0] k,
    output logic                emit,
    output out_item_t           result
);
    localparam int unsigned WIDE_W = VALUE_W + ACC_W;
    localparam logic [VALUE_W-1:0] MAXV = VALUE_W'((64'd1 << VALUE_BITS) - 64'd1);

    logic               in_suffix_reg, in_suffix_next;
    logic [VALUE_W-1:0] prefix_count_reg, prefix_count_next;
    logic [K_W-1:0]     suffix_index_reg, suffix_index_next;
    logic [ACC_W-1:0]   suffix_acc_reg, suffix_acc_next;
    logic               count_sat_reg, count_sat_next;

    logic [ACC_W-1:0]   acc_upd;
    logic [K_W-1:0]     idx_upd;
    logic [ACC_W-1:0]   acc_fin;
    logic [WIDE_W-1:0]  wide_val;
    logic               ovf;

    always_comb begin
        in_suffix_next    = in_suffix_reg;
        prefix_count_next = prefix_count_reg;
        suffix_index_next = suffix_index_reg;
        suffix_acc_next   = suffix_acc_reg;
        count_sat_next    = count_sat_reg;
        emit              = 1'b0;

        acc_upd = suffix_acc_reg;
        if (suffix_index_reg < K_MAX) begin
            acc_upd = suffix_acc_reg | (ACC_W'(code_bit) << suffix_index_reg[3:0]);
        end
        idx_upd = suffix_index_reg + K_W'(1);
        acc_fin = acc_upd;

        if (!in_suffix_reg) begin
            if (code_bit) begin
                if (&prefix_count_reg) begin
                    count_sat_next = 1'b1;
                end else begin
                    prefix_count_next = prefix_count_reg + VALUE_W'(1);
                end
            end else begin
                in_suffix_next    = 1'b1;
                suffix_index_next = '0;
                suffix_acc_next   = '0;
                acc_fin           = '0;
                emit              = (k == '0);
            end
        end else begin
            suffix_index_next = idx_upd;
            suffix_acc_next   = acc_upd;
            if (idx_upd >= k) begin
                acc_fin = acc_upd & ~({ACC_W{1'b1}} << k);
                emit    = 1'b1;
            end
        end

        if (emit) begin
            in_suffix_next    = 1'b0;
            prefix_count_next = '0;
            suffix_index_next = '0;
            suffix_acc_next   = '0;
            count_sat_next    = 1'b0;
        end

        // suffix sits below the shifted prefix, so OR is the sum
        wide_val = (WIDE_W'(prefix_count_reg) << k) | WIDE_W'(acc_fin);
        ovf      = count_sat_reg || ((wide_val >> VALUE_BITS) != '0);

        result                = '0;
        result.result_kind    = KIND_DECODE;
        result.value_overflow = ovf;
        result.decoded_value  = ovf ? MAXV : wide_val[VALUE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_suffix_reg    <= 1'b0;
            prefix_count_reg <= '0;
            suffix_index_reg <= '0;
            suffix_acc_reg   <= '0;
            count_sat_reg    <= 1'b0;
        end else if (step) begin
            in_suffix_reg    <= in_suffix_next;
            prefix_count_reg <= prefix_count_next;
            suffix_index_reg <= suffix_index_next;
            suffix_acc_reg   <= suffix_acc_next;
            count_sat_reg    <= count_sat_next;
        end
    end
endmodule
`default_nettype wire

// ===== sv/rice_codec.sv =====
// Top level of the Rice codec: input register, encoder/decoder, result register.
`default_nettype none
// Rice codec with parameter k (register suffix_bits, clamped to 16). In encode
// mode every item gives one result: q one-bits (q = value >> k), a zero, then
// the k low bits, bit 0 of code_word sent first; codes longer than
// MAX_CODE_BITS are flagged too_long with an empty word. In decode mode each
// item carries one code bit and a result appears only when a codeword ends;
// values above VALUE_BITS bits saturate and set value_overflow. Rate: one
// item per cycle while the output is not stalled. An item is captured in the
// input register, then passes the encoder or decoder logic into the result
// register. The result register advances whenever it is empty or being
// drained, the input register also whenever it is empty, so a stalled
// output holds at most two items. Configuration writes are always accepted
// and must only be issued while the block is idle.
module rice_codec
    import rc_pkg::*;
#(
    parameter int unsigned MAX_CODE_BITS = 64,
    parameter int unsigned VALUE_BITS    = 32
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    // input items
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire in_item_t       s_data,
    // result items
    output logic                m_valid,
    input  wire logic           m_ready,
    output out_item_t           m_data,
    // configuration writes
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire cfg_reg_t       cfg_index,
    input  wire logic [K_W-1:0] cfg_wdata
);
    // configuration
    mode_t          mode_reg;
    logic [K_W-1:0] suffix_bits_reg;
    logic [K_W-1:0] k;

    // pipeline
    logic           in_valid_reg;
    in_item_t       in_data_reg;
    logic           out_valid_reg, out_valid_next;
    out_item_t      out_data_reg, out_data_next;
    logic           advance;
    logic           work;

    out_item_t      enc_res;
    out_item_t      dec_res;
    logic           dec_emit;

    assign cfg_ready = 1'b1;
    assign k         = (suffix_bits_reg > K_MAX) ? K_MAX : suffix_bits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_ENCODE;
            suffix_bits_reg <= K_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MODE:   mode_reg        <= mode_t'(cfg_wdata[0]);
                CFG_SUFFIX: suffix_bits_reg <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // The result stage moves on an empty slot or a drain; the input stage also fills when empty.
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign work    = in_valid_reg && advance;

    rc_enc #(
        .MAX_CODE_BITS(MAX_CODE_BITS)
    ) u_enc (
        .value_in (in_data_reg.value_in),
        .k        (k),
        .result   (enc_res)
    );

    rc_dec #(
        .VALUE_BITS(VALUE_BITS)
    ) u_dec (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (work && (mode_reg == MODE_DECODE)),
        .code_bit (in_data_reg.code_bit),
        .k        (k),
        .emit     (dec_emit),
        .result   (dec_res)
    );

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        if (work) begin
            if (mode_reg == MODE_DECODE) begin
                out_valid_next = dec_emit;
                out_data_next  = dec_res;
            end else begin
                out_valid_next = 1'b1;
                out_data_next  = enc_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (work) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // An oversized code leaves an empty word.
    a_too_long_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.too_long) |-> (m_data.code_word == '0 && m_data.code_length == '0))
        else $error("too_long result carries code bits");

    // Encode results fit the configured maximum length.
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.result_kind == KIND_ENCODE)
            |-> (m_data.code_length <= LEN_W'(MAX_CODE_BITS)))
        else $error("code_length above maximum");

    // Encode results never carry decoder fields and vice versa.
    a_kind_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.result_kind == KIND_ENCODE)
            ? (m_data.decoded_value == '0 && !m_data.value_overflow)
            : (m_data.code_word == '0 && m_data.code_length == '0 && !m_data.too_long)))
        else $error("result fields mixed between kinds");

    // An accepted item in the input stage is consumed once the output drains.
    a_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !m_valid) |=> (!in_valid_reg || $past(s_valid && s_ready)))
        else $error("input stage stuck with free output");

endmodule
`default_nettype wire
